// ----- sv/lfuct_pkg.sv -----
`timescale 1ns / 1ps

package lfuct_pkg;

  // Table geometry
  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HELD_W     = $clog2(CAPACITY + 1);
  localparam int CAP_W      = 5;
  localparam int DATA_W     = 32;

  typedef logic [IDX_W-1:0]      age_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [HELD_W-1:0]     held_t;
  typedef logic [CAP_W-1:0]      cap_t;
  typedef logic [DATA_W-1:0]     word_t;
  typedef logic [CAPACITY-1:0]   lane_vec_t;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  localparam cap_t CAP_RESET = cap_t'(16);

  // One request
  typedef struct packed {
    op_t          op;
    logic [31:0]  key;
    logic [31:0]  value;
  } item_t;

  // One response
  typedef struct packed {
    logic         hit;
    logic [31:0]  read_value;
    logic         evicted;
    logic [31:0]  evicted_key;
  } result_t;

endpackage

// ----- sv/lfuct_table.sv -----
`timescale 1ns / 1ps

module lfuct_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr,
  input  lfuct_pkg::cap_t     cfg_data,
  input  lfuct_pkg::item_t    item,
  input  logic                fire,
  output lfuct_pkg::result_t  result
);

  // Entry storage
  lfuct_pkg::lane_vec_t valid_r, valid_nxt;
  lfuct_pkg::word_t     key_r   [lfuct_pkg::CAPACITY];
  lfuct_pkg::word_t     key_nxt [lfuct_pkg::CAPACITY];
  lfuct_pkg::word_t     val_r   [lfuct_pkg::CAPACITY];
  lfuct_pkg::word_t     val_nxt [lfuct_pkg::CAPACITY];
  lfuct_pkg::cnt_t      cnt_r   [lfuct_pkg::CAPACITY];
  lfuct_pkg::cnt_t      cnt_nxt [lfuct_pkg::CAPACITY];
  lfuct_pkg::age_t      age_r   [lfuct_pkg::CAPACITY];
  lfuct_pkg::age_t      age_nxt [lfuct_pkg::CAPACITY];
  lfuct_pkg::held_t     held_r, held_nxt;
  lfuct_pkg::cap_t      cfg_r;

  lfuct_pkg::lane_vec_t hit_oh, victim_oh, free_oh, tgt_oh;
  logic                 hit_any, full, cap_zero, is_put;
  logic                 do_touch, do_insert, do_evict, age_all, act;
  lfuct_pkg::age_t      old_age;
  lfuct_pkg::word_t     sel_value, victim_key;

  // Key match on every lane; keys are unique, so at most one lane hits
  always_comb begin
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      hit_oh[j] = valid_r[j] && (key_r[j] == item.key);
    end
    hit_any = |hit_oh;
  end

  // Victim: lowest count, and among equal counts the oldest. Ages form a
  // permutation over the valid lanes, so exactly one lane wins.
  always_comb begin
    logic beats;
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      beats = valid_r[j];
      for (int k = 0; k < lfuct_pkg::CAPACITY; k++) begin
        if (k != j && valid_r[k] &&
            !({cnt_r[j], ~age_r[j]} < {cnt_r[k], ~age_r[k]})) begin
          beats = 1'b0;
        end
      end
      victim_oh[j] = beats;
    end
  end

  // Lowest free lane
  always_comb begin
    logic lower_full;
    lower_full = 1'b1;
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      free_oh[j] = lower_full && !valid_r[j];
      lower_full = lower_full && valid_r[j];
    end
  end

  // Decide what this beat does
  always_comb begin
    cap_zero  = (cfg_r == '0);
    full      = (32'(held_r) >= 32'(cfg_r)) || (32'(held_r) >= lfuct_pkg::CAPACITY);
    is_put    = (item.op == lfuct_pkg::OP_PUT);
    do_touch  = hit_any && (!is_put || !cap_zero);
    do_insert = is_put && !cap_zero && !hit_any;
    do_evict  = do_insert && full;
    age_all   = do_insert && !full;
    act       = fire && (do_touch || do_insert);
    if (do_touch) begin
      tgt_oh = hit_oh;
    end else if (do_evict) begin
      tgt_oh = victim_oh;
    end else begin
      tgt_oh = free_oh;
    end
  end

  // One-hot selects of stored fields
  always_comb begin
    old_age    = '0;
    sel_value  = '0;
    victim_key = '0;
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      old_age    = old_age    | (age_r[j] & {lfuct_pkg::IDX_W{tgt_oh[j]}});
      sel_value  = sel_value  | (val_r[j] & {lfuct_pkg::DATA_W{hit_oh[j]}});
      victim_key = victim_key | (key_r[j] & {lfuct_pkg::DATA_W{victim_oh[j]}});
    end
  end

  // Response fields
  always_comb begin
    result.hit         = hit_any;
    result.read_value  = is_put ? '0 : (hit_any ? sel_value : '1);
    result.evicted     = do_evict;
    result.evicted_key = do_evict ? victim_key : '0;
  end

  // Next state of every lane
  always_comb begin
    valid_nxt = valid_r;
    held_nxt  = held_r;
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      key_nxt[j] = key_r[j];
      val_nxt[j] = val_r[j];
      cnt_nxt[j] = cnt_r[j];
      age_nxt[j] = age_r[j];
      if (act) begin
        if (tgt_oh[j]) begin
          age_nxt[j] = '0;
          if (do_touch) begin
            if (cnt_r[j] != '1) begin
              cnt_nxt[j] = cnt_r[j] + lfuct_pkg::cnt_t'(1);
            end
            if (is_put) begin
              val_nxt[j] = item.value;
            end
          end else begin
            valid_nxt[j] = 1'b1;
            key_nxt[j]   = item.key;
            val_nxt[j]   = item.value;
            cnt_nxt[j]   = lfuct_pkg::cnt_t'(1);
          end
        end else if (valid_r[j] && (age_all || (age_r[j] < old_age))) begin
          age_nxt[j] = age_r[j] + lfuct_pkg::age_t'(1);
        end
      end
    end
    if (act && age_all) begin
      held_nxt = held_r + lfuct_pkg::held_t'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      held_r  <= '0;
      cfg_r   <= lfuct_pkg::CAP_RESET;
    end else begin
      valid_r <= valid_nxt;
      held_r  <= held_nxt;
      if (cfg_wr) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < lfuct_pkg::CAPACITY; j++) begin
      key_r[j] <= key_nxt[j];
      val_r[j] <= val_nxt[j];
      cnt_r[j] <= cnt_nxt[j];
      age_r[j] <= age_nxt[j];
    end
  end

`ifndef ASSERT_OFF
  a_held_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(held_r))
    else $error("entry count out of step with valid lanes");

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_oh))
    else $error("key present in more than one lane");

  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_evict) |-> $onehot(victim_oh))
    else $error("eviction without a single victim");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && age_all) |=> (held_r == $past(held_r) + lfuct_pkg::held_t'(1)))
    else $error("insert into free lane did not grow the table");
`endif

endmodule

// ----- sv/lfuct_out_reg.sv -----
`timescale 1ns / 1ps

module lfuct_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  lfuct_pkg::result_t res,
  output logic               load_ok,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,  // read_value, evicted_key
  output logic [1:0]         out_tuser   // hit, evicted
);

  logic               v_r;
  lfuct_pkg::result_t res_r;

  // A new result may enter when the register is empty or being drained
  assign load_ok = !v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load_ok) begin
      v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = {res_r.evicted_key, res_r.read_value};
  assign out_tuser  = {res_r.evicted, res_r.hit};

endmodule

// ----- sv/lfu_cache_table_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                    | tuser (low bit up)
// in_     | slave     | key[31:0], value[63:32]               | op (0 get, 1 put)
// out_    | master    | read_value[31:0], evicted_key[63:32]  | hit[0], evicted[1]
// cfg_    | write     | capacity_in_use[4:0]                  | -
//
// Lookup, victim choice and table update complete while a beat sits in the input
// register; its result is then registered in the output register.
// One beat per cycle is sustained while out_tready stays high.
// Reset (rst_n low, synchronous) empties the table and sets capacity to 16.
// A stalled output register holds the input register, which then holds in_tready low.

module lfu_cache_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key, value
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // read_value, evicted_key
  output logic [1:0]  out_tuser,  // hit, evicted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity_in_use
);

  logic               item_v_r, item_v_nxt;
  lfuct_pkg::item_t   item_r;
  lfuct_pkg::result_t res;
  logic               load_ok, fire;

  // Input register takes a new beat when empty or when its beat moves into the output register
  assign fire      = item_v_r && load_ok;
  assign in_tready = !item_v_r || fire;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_tready) begin
      item_v_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op    <= lfuct_pkg::op_t'(in_tuser);
      item_r.key   <= in_tdata[31:0];
      item_r.value <= in_tdata[63:32];
    end
  end

  lfuct_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .item     (item_r),
    .fire     (fire),
    .result   (res)
  );

  lfuct_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
